@@ design/hcws_pkg.sv @@
// shared types and constants for the hash-checked word sync search
`timescale 1ns / 1ps

package hcws_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned HALF_W      = 32;
  localparam int unsigned OFFSET_STEP = 2;
  localparam int unsigned NUM_OFFSETS = WORD_W / OFFSET_STEP;
  localparam int unsigned OFF_W       = $clog2(NUM_OFFSETS);
  localparam int unsigned HALF_SHIFT  = 16;

  localparam logic [HALF_W-1:0] HASH_MULT = 32'h045D_9F3B;
  localparam logic [OFF_W-1:0]  LAST_OFF  = OFF_W'(NUM_OFFSETS - 1);

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // request into the hash pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } hash_req_t;

  // response out of the hash pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic match;
  } hash_rsp_t;

  // x ^ (x >> 16)
  function automatic logic [HALF_W-1:0] xor_shift(input logic [HALF_W-1:0] x);
    return x ^ (x >> HALF_SHIFT);
  endfunction

endpackage

@@ design/hash_checked_word_sync_search_unit.sv @@
// Hash-checked word sync search. Each accepted 64-bit item is scanned at the 32
// even bit offsets of the previous word followed by this one; the hash pipeline
// takes one offset per cycle and has to empty before data_stall falls again; a
// new item is taken only once the last one is done, and later still while a
// found message still waits on message_stall. At most one message (the lowest
// matching offset) comes out per item; the word then becomes the previous word.
// After reset the previous word is zero.
`timescale 1ns / 1ps

module hash_checked_word_sync_search_unit import hcws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              data_valid,
  output logic              data_stall,
  input  logic [WORD_W-1:0] data_word,
  output logic              message_valid,
  input  logic              message_stall,
  output logic [HALF_W-1:0] message
);

  state_t            state, state_next;
  logic [OFF_W-1:0]  offset;
  logic              found;
  logic [HALF_W-1:0] found_msg;
  logic              accept;
  logic              out_load;
  logic              out_free;
  hash_req_t         req;
  hash_rsp_t         rsp;
  logic [HALF_W-1:0] rsp_msg;
  logic [HALF_W-1:0] win_tag, win_msg;

  assign accept   = data_valid && !data_stall;
  assign out_free = !message_valid || !message_stall;

  hcws_window u_window (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .shift     (req.valid),
    .data_word (data_word),
    .tag       (win_tag),
    .msg       (win_msg)
  );

  hcws_hash_unit u_hash (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .tag     (win_tag),
    .msg     (win_msg),
    .rsp     (rsp),
    .rsp_msg (rsp_msg)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (data_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (offset == LAST_OFF) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (rsp.valid && rsp.last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!found || out_free) state_next = ST_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    data_stall = 1'b1;
    req.valid  = 1'b0;
    req.last   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        data_stall = 1'b0;
      end
      ST_SCAN: begin
        req.valid = 1'b1;
        req.last  = (offset == LAST_OFF);
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        out_load = found && out_free;
      end
    endcase
  end

  // state register and offset counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      offset <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        offset <= '0;
      end else if (req.valid) begin
        offset <= offset + 1'b1;
      end
    end
  end

  // keep the first match of the item
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (rsp.valid && rsp.match && !found) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid && rsp.match && !found) begin
      found_msg <= rsp_msg;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      message_valid <= 1'b0;
    end else if (out_load) begin
      message_valid <= 1'b1;
    end else if (!message_stall) begin
      message_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      message <= found_msg;
    end
  end

`ifndef SYNTHESIS
  // an accepted item starts the offset scan
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN && offset == '0))
    else $error("accepted item did not start a scan");

  // hash results only come back while an item is being worked on
  a_rsp_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("hash response outside of a scan");

  // a new message only appears after a match was found
  a_msg_found: assert property (@(posedge clk) disable iff (rst)
    $rose(message_valid) |-> ($past(state) == ST_FINISH && $past(found)))
    else $error("message issued without a match");
`endif

endmodule

@@ design/hcws_window.sv @@
// window shifter: holds the previous word and slides the 64-bit window
`timescale 1ns / 1ps

module hcws_window import hcws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              shift,
  input  logic [WORD_W-1:0] data_word,
  output logic [HALF_W-1:0] tag,
  output logic [HALF_W-1:0] msg
);

  logic [2*WORD_W-1:0] pair;
  logic [WORD_W-1:0]   previous_word;

  // previous word is architectural state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_word <= '0;
    end else if (load) begin
      previous_word <= data_word;
    end
  end

  // previous and current word side by side, moved two bits per offset
  always_ff @(posedge clk) begin
    if (load) begin
      pair <= {previous_word, data_word};
    end else if (shift) begin
      pair <= pair << OFFSET_STEP;
    end
  end

  // upper half of the window is the tag, lower half the message
  assign tag = pair[2*WORD_W-1 -: HALF_W];
  assign msg = pair[2*WORD_W-HALF_W-1 -: HALF_W];

endmodule

@@ design/hcws_hash_unit.sv @@
// three-stage hash pipeline with tag compare, one window per cycle
`timescale 1ns / 1ps

module hcws_hash_unit import hcws_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  hash_req_t         req,
  input  logic [HALF_W-1:0] tag,
  input  logic [HALF_W-1:0] msg,
  output hash_rsp_t         rsp,
  output logic [HALF_W-1:0] rsp_msg
);

  logic              s1_valid, s1_last;
  logic [HALF_W-1:0] s1_tag, s1_msg, s1_x;
  logic              s2_valid, s2_last;
  logic [HALF_W-1:0] s2_tag, s2_msg, s2_x;
  logic [HALF_W-1:0] mul1, mul2, hash;

  // first and second mixing rounds, low 32 bits of each product kept
  assign mul1 = xor_shift(msg) * HASH_MULT;
  assign mul2 = xor_shift(s1_x) * HASH_MULT;
  assign hash = xor_shift(s2_x);

  // control of the pipeline and the response
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      rsp      <= '0;
    end else begin
      s1_valid  <= req.valid;
      s2_valid  <= s1_valid;
      rsp.valid <= s2_valid;
      rsp.last  <= s2_last;
      rsp.match <= (s2_tag != '0) && (hash == s2_tag);
    end
  end

  // payload of the pipeline
  always_ff @(posedge clk) begin
    s1_last <= req.last;
    s1_tag  <= tag;
    s1_msg  <= msg;
    s1_x    <= mul1;
    s2_last <= s1_last;
    s2_tag  <= s1_tag;
    s2_msg  <= s1_msg;
    s2_x    <= mul2;
    rsp_msg <= s2_msg;
  end

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the hash-checked word sync search unit
`timescale 1ns / 1ps

module tb;
  import hcws_pkg::*;

  // one row of the directed table
  typedef struct {
    logic [WORD_W-1:0] word;
    bit                typed;
    bit                hit;
    logic [HALF_W-1:0] want;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              data_valid;
  logic              data_stall;
  logic [WORD_W-1:0] data_word;
  logic              message_valid;
  logic              message_stall;
  logic [HALF_W-1:0] message;

  logic [HALF_W-1:0] expected_messages[$];
  logic [WORD_W-1:0] last_word;
  stim_row_t         directed_rows[$];
  int                mismatch_count;
  int                items_accepted;
  bit                gaps_on;
  int                hold_left;
  bit                hold_done;

  hash_checked_word_sync_search_unit dut (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .data_word     (data_word),
    .message_valid (message_valid),
    .message_stall (message_stall),
    .message       (message)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // 32-bit integer hash, wrapping arithmetic
  function automatic logic [HALF_W-1:0] mix_hash(input logic [HALF_W-1:0] v);
    logic [HALF_W-1:0] x;
    x = v;
    x = (x ^ (x >> HALF_SHIFT)) * HASH_MULT;
    x = (x ^ (x >> HALF_SHIFT)) * HASH_MULT;
    x = x ^ (x >> HALF_SHIFT);
    return x;
  endfunction

  // lowest even offset whose tag is nonzero and equals the hash of its message
  function automatic bit predict_message(input logic [WORD_W-1:0] older,
                                         input logic [WORD_W-1:0] newer,
                                         output logic [HALF_W-1:0] msg);
    logic [2*WORD_W-1:0] stream;
    logic [WORD_W-1:0]   win;
    stream = {older, newer};
    msg = '0;
    for (int off = 0; off < WORD_W; off += OFFSET_STEP) begin
      win = stream[2*WORD_W-1-off -: WORD_W];
      if (win[WORD_W-1:HALF_W] != '0 && mix_hash(win[HALF_W-1:0]) == win[WORD_W-1:HALF_W]) begin
        msg = win[HALF_W-1:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // two words with a {tag, message} window planted at the given offset
  task automatic plant_window(input int off, input logic [WORD_W-1:0] win,
                              output logic [WORD_W-1:0] older,
                              output logic [WORD_W-1:0] newer);
    logic [2*WORD_W-1:0] stream;
    stream = {$urandom, $urandom, $urandom, $urandom};
    stream[2*WORD_W-1-off -: WORD_W] = win;
    older = stream[2*WORD_W-1 -: WORD_W];
    newer = stream[WORD_W-1:0];
  endtask

  // mismatch reporting
  task automatic report_mismatch(input string what, input logic [HALF_W-1:0] got,
                                 input logic [HALF_W-1:0] want);
    $display("mismatch at %0t: %s, got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // offer one item, wait for acceptance, then update the expected messages
  task automatic send_item(input logic [WORD_W-1:0] w, input bit typed, input bit hit,
                           input logic [HALF_W-1:0] want);
    bit                found;
    logic [HALF_W-1:0] msg;
    while (gaps_on && $urandom_range(99) < 15) begin
      data_valid = 1'b0;
      data_word  = {$urandom, $urandom};
      @(negedge clk);
    end
    data_valid = 1'b1;
    data_word  = w;
    do @(posedge clk); while (data_stall);
    found = predict_message(last_word, w, msg);
    last_word = w;
    if (typed) begin
      found = hit;
      msg   = want;
    end
    if (found) begin
      expected_messages.push_back(msg);
    end
    items_accepted++;
    @(negedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    if (!rst && message_valid && !message_stall) begin
      if (expected_messages.size() == 0) begin
        report_mismatch("message with none expected", message, '0);
      end else begin
        if (message !== expected_messages[0])
          report_mismatch("message", message, expected_messages[0]);
        void'(expected_messages.pop_front());
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the block
  initial begin
    message_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        message_stall = 1'b1;
        hold_left--;
      end else if (!hold_done && items_accepted >= 300) begin
        message_stall = 1'b1;
        hold_left = 400;
        hold_done = 1'b1;
      end else begin
        message_stall = !rst && gaps_on && ($urandom_range(99) < 15);
      end
    end
  end

  // run time limit
  initial begin
    #2_000_000;
    $display("** hash_checked_word_sync_search_unit: FAILED **");
    $finish;
  end

  // stimulus
  initial begin
    logic [HALF_W-1:0] m1, m2, t1, t2;
    logic [WORD_W-1:0] w_old, w_new;
    int                rand_items;
    int                pick;
    int                off;
    int                wait_cycles;

    rst = 1'b1;
    data_valid = 1'b0;
    data_word = '0;
    mismatch_count = 0;
    items_accepted = 0;
    gaps_on = 1'b1;
    last_word = '0;

    // zero word after reset: zero tag, no message
    directed_rows.push_back('{64'h0, 1'b1, 1'b0, 32'h0});
    // previous word still zero: match with a short tag at the last offset
    m1 = 32'h1234_5677;
    t1 = mix_hash(m1);
    while (t1 == '0 || t1[31:30] != 2'b00) begin
      m1++;
      t1 = mix_hash(m1);
    end
    directed_rows.push_back('{{t1[29:0], m1, 2'b11}, 1'b0, 1'b0, 32'h0});
    // extremes and alternating patterns
    directed_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{64'h0, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{64'h0, 1'b1, 1'b0, 32'h0});
    directed_rows.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{64'h5555_5555_5555_5555, 1'b0, 1'b0, 32'h0});
    // planted matches at the first, last and middle offsets
    m1 = 32'hDEAD_BEEF;
    plant_window(0, {mix_hash(m1), m1}, w_old, w_new);
    directed_rows.push_back('{w_old, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{w_new, 1'b0, 1'b0, 32'h0});
    plant_window(62, {mix_hash(32'h0000_0001), 32'h0000_0001}, w_old, w_new);
    directed_rows.push_back('{w_old, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{w_new, 1'b0, 1'b0, 32'h0});
    plant_window(32, {mix_hash(32'h8000_0000), 32'h8000_0000}, w_old, w_new);
    directed_rows.push_back('{w_old, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{w_new, 1'b0, 1'b0, 32'h0});
    // several matches: offsets 0 and 62 both hit, the lower one wins
    m1 = 32'h0BAD_F00D;
    t1 = mix_hash(m1);
    m2 = 32'h0000_1000;
    t2 = mix_hash(m2);
    while (t2 == '0 || t2[31:30] != m1[1:0]) begin
      m2++;
      t2 = mix_hash(m2);
    end
    directed_rows.push_back('{{t1, m1}, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{{t2[29:0], m2, 2'b01}, 1'b0, 1'b0, 32'h0});
    // tag one bit off from the hash
    plant_window(20, {mix_hash(32'h0F0F_0F0F) ^ 32'h0000_0400, 32'h0F0F_0F0F}, w_old, w_new);
    directed_rows.push_back('{w_old, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{w_new, 1'b0, 1'b0, 32'h0});
    // zero tag over a zero message inside otherwise random bits
    plant_window(40, 64'h0, w_old, w_new);
    directed_rows.push_back('{w_old, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{w_new, 1'b0, 1'b0, 32'h0});
    // largest message
    plant_window(2, {mix_hash(32'hFFFF_FFFF), 32'hFFFF_FFFF}, w_old, w_new);
    directed_rows.push_back('{w_old, 1'b0, 1'b0, 32'h0});
    directed_rows.push_back('{w_new, 1'b0, 1'b0, 32'h0});

    // reset
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part
    foreach (directed_rows[i])
      send_item(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].hit,
                directed_rows[i].want);

    // random part: mostly planted windows, the rest broken ones and noise
    rand_items = 0;
    while (rand_items < 800) begin
      gaps_on = !(rand_items >= 400 && rand_items < 550);
      pick = $urandom_range(99);
      off = OFFSET_STEP * $urandom_range(31);
      m1 = ($urandom_range(3) == 0) ? HALF_W'($urandom_range(255)) : HALF_W'($urandom);
      t1 = mix_hash(m1);
      if (pick >= 60 && pick < 70)
        t1 ^= HALF_W'(1) << $urandom_range(31);
      plant_window(off, {t1, m1}, w_old, w_new);
      if (pick < 70) begin
        send_item(w_old, 1'b0, 1'b0, '0);
        send_item(w_new, 1'b0, 1'b0, '0);
        rand_items += 2;
      end else if (pick < 75) begin
        // sequence cut short: first word followed by noise
        send_item(w_old, 1'b0, 1'b0, '0);
        send_item({$urandom, $urandom}, 1'b0, 1'b0, '0);
        rand_items += 2;
      end else if (pick < 80) begin
        send_item(($urandom_range(1) == 0) ? '0 : '1, 1'b0, 1'b0, '0);
        rand_items++;
      end else begin
        send_item({$urandom, $urandom}, 1'b0, 1'b0, '0);
        rand_items++;
      end
    end
    data_valid = 1'b0;

    // drain
    gaps_on = 1'b0;
    wait_cycles = 0;
    while (expected_messages.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    foreach (expected_messages[i])
      report_mismatch("message never arrived", '0, expected_messages[i]);
    repeat (100) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** hash_checked_word_sync_search_unit: PASSED **");
    end else begin
      $display("** hash_checked_word_sync_search_unit: FAILED **");
    end
    $finish;
  end

endmodule
